### rtl/ogb_pkg.sv
// Package with the shared widths, configuration and pipeline types of the grid binning block.
`timescale 1ns / 1ps
package ogb_pkg;

  localparam int COORD_W = 24;
  localparam int EDGE_W  = 20;
  localparam int CELL_W  = 8;
  localparam int CNT_W   = 9;
  localparam int SIZE_W  = COORD_W - 1;
  localparam int C2_W    = COORD_W;          // doubled cube size and margin
  localparam int P_W     = COORD_W + 3;      // doubled midpoint minus doubled origin
  localparam int REM_W   = P_W - 1;          // non-negative part of the midpoint
  localparam int QB      = CNT_W;            // quotient bits worked out, one per stage
  localparam int DSH_W   = C2_W + QB + 1;    // shifted divisor compare width
  localparam int LO_W    = CELL_W + C2_W;    // cell index times doubled cube size
  localparam int S_W     = LO_W + 4;         // signed width of the bound tests
  localparam int IDX_W   = 4;
  localparam int NCOMB   = 8;

  typedef enum logic [IDX_W-1:0] {
    REG_ORIGIN_X  = 4'd0,
    REG_ORIGIN_Y  = 4'd1,
    REG_ORIGIN_Z  = 4'd2,
    REG_CUBE_SIZE = 4'd3,
    REG_MARGIN    = 4'd4,
    REG_CELLS_X   = 4'd5,
    REG_CELLS_Y   = 4'd6,
    REG_CELLS_Z   = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] org;
    logic [C2_W-1:0]         c2;
    logic [C2_W-1:0]         d2;
    logic [2:0][CELL_W-1:0]  last_cell;
  } cfg_t;

  typedef struct packed {
    logic [EDGE_W-1:0]     id;
    logic [2:0][P_W-1:0]   p;
    logic [2:0]            neg;
    logic [2:0]            sat;
    logic [2:0][REM_W-1:0] rem;
    logic [2:0][QB-1:0]    q;
  } div_t;

  typedef struct packed {
    logic [EDGE_W-1:0]      id;
    logic [NCOMB-1:0]       mask;
    logic [2:0][CELL_W-1:0] home;
    logic [2:0][CELL_W-1:0] nb;
  } hit_t;

endpackage

### rtl/ogb_front.sv
// Midpoint stage and the bit-per-stage restoring divider that finds each axis quotient.
`timescale 1ns / 1ps
module ogb_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [ogb_pkg::EDGE_W-1:0]           edge_id_i,
  input  logic [2:0][ogb_pkg::COORD_W-1:0]     first_i,
  input  logic [2:0][ogb_pkg::COORD_W-1:0]     second_i,
  input  ogb_pkg::cfg_t                        cfg_i,
  output logic                                 valid_o,
  output ogb_pkg::div_t                        div_o
);

  logic                                  s0_valid_q;
  logic [ogb_pkg::EDGE_W-1:0]            s0_id_q;
  logic [2:0][ogb_pkg::P_W-1:0]          s0_p_q, s0_p_d;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s0_p_d[a] = ogb_pkg::P_W'($signed(first_i[a])) + ogb_pkg::P_W'($signed(second_i[a]))
                - (ogb_pkg::P_W'($signed(cfg_i.org[a])) <<< 1);
    end
  end

  // Seed of the divider: negative points go to cell zero, huge quotients saturate.
  ogb_pkg::div_t seed;
  always_comb begin
    seed.id = s0_id_q;
    seed.p  = s0_p_q;
    seed.q  = '0;
    for (int a = 0; a < 3; a++) begin
      seed.neg[a] = s0_p_q[a][ogb_pkg::P_W-1];
      seed.rem[a] = seed.neg[a] ? '0 : s0_p_q[a][ogb_pkg::REM_W-1:0];
      seed.sat[a] = ogb_pkg::DSH_W'(seed.rem[a])
                  >= (ogb_pkg::DSH_W'(cfg_i.c2) << ogb_pkg::QB);
    end
  end

  ogb_pkg::div_t           dv_in [ogb_pkg::QB];
  ogb_pkg::div_t           dv_d  [ogb_pkg::QB];
  ogb_pkg::div_t           dv_q  [ogb_pkg::QB];
  logic [ogb_pkg::QB-1:0]  dv_valid_q;

  // Restoring division, one quotient bit per stage, most significant bit first.
  always_comb begin
    logic [ogb_pkg::DSH_W-1:0] dsh;
    dv_in[0] = seed;
    for (int k = 1; k < ogb_pkg::QB; k++) begin
      dv_in[k] = dv_q[k-1];
    end
    for (int k = 0; k < ogb_pkg::QB; k++) begin
      dv_d[k] = dv_in[k];
      dsh = ogb_pkg::DSH_W'(cfg_i.c2) << (ogb_pkg::QB - 1 - k);
      for (int a = 0; a < 3; a++) begin
        if (ogb_pkg::DSH_W'(dv_in[k].rem[a]) >= dsh) begin
          dv_d[k].rem[a] = ogb_pkg::REM_W'(ogb_pkg::DSH_W'(dv_in[k].rem[a]) - dsh);
          dv_d[k].q[a][ogb_pkg::QB - 1 - k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      dv_valid_q <= '0;
    end else if (en_i) begin
      s0_valid_q <= valid_i;
      dv_valid_q <= {dv_valid_q[ogb_pkg::QB-2:0], s0_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_id_q <= edge_id_i;
      s0_p_q  <= s0_p_d;
      for (int k = 0; k < ogb_pkg::QB; k++) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  assign valid_o = dv_valid_q[ogb_pkg::QB-1];
  assign div_o   = dv_q[ogb_pkg::QB-1];

endmodule

### rtl/ogb_class.sv
// Home cell selection, cell bounds, margin tests and the neighbor hit mask.
`timescale 1ns / 1ps
module ogb_class (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  ogb_pkg::div_t  div_i,
  input  ogb_pkg::cfg_t  cfg_i,
  output logic           valid_o,
  output ogb_pkg::hit_t  hit_o
);

  // Stage one: clamp the quotient and scale back to the cell's low bound.
  logic                                   c1_valid_q;
  logic [ogb_pkg::EDGE_W-1:0]             c1_id_q;
  logic [2:0][ogb_pkg::CELL_W-1:0]        c1_cell_q, c1_cell_d;
  logic [2:0][ogb_pkg::LO_W-1:0]          c1_lo_q, c1_lo_d;
  logic [2:0][ogb_pkg::P_W-1:0]           c1_p_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (div_i.neg[a]) begin
        c1_cell_d[a] = '0;
      end else if (div_i.sat[a] ||
                   div_i.q[a] > ogb_pkg::QB'(cfg_i.last_cell[a])) begin
        c1_cell_d[a] = cfg_i.last_cell[a];
      end else begin
        c1_cell_d[a] = div_i.q[a][ogb_pkg::CELL_W-1:0];
      end
      c1_lo_d[a] = ogb_pkg::LO_W'(c1_cell_d[a]) * ogb_pkg::LO_W'(cfg_i.c2);
    end
  end

  // Stage two: the face tests, all in signed arithmetic of one width.
  logic                                   c2_valid_q;
  logic [ogb_pkg::EDGE_W-1:0]             c2_id_q;
  logic [2:0][ogb_pkg::CELL_W-1:0]        c2_cell_q;
  logic [2:0]                             c2_in_q, c2_dirm_q, c2_dir_q, c2_hnb_q, c2_hh_q;
  logic [2:0]                             in_d, dirm_d, dir_d, hnb_d, hh_d;

  always_comb begin
    logic signed [ogb_pkg::S_W-1:0] pp, lo, hi, cs, dd;
    logic dm, dp, hm, hp;
    for (int a = 0; a < 3; a++) begin
      pp = ogb_pkg::S_W'($signed(c1_p_q[a]));
      lo = $signed(ogb_pkg::S_W'(c1_lo_q[a]));
      cs = $signed(ogb_pkg::S_W'(cfg_i.c2));
      dd = $signed(ogb_pkg::S_W'(cfg_i.d2));
      hi = lo + cs;
      in_d[a] = !((pp < lo + dd) || (pp > hi - dd));
      dm = (pp - dd < lo);
      dp = !dm && (pp + dd > hi);
      if (c1_cell_q[a] == '0) dm = 1'b0;
      if (c1_cell_q[a] == cfg_i.last_cell[a]) dp = 1'b0;
      hm = (pp > lo - cs - dd) && (pp < lo + dd);
      hp = (pp > hi - dd) && (pp < hi + cs + dd);
      dirm_d[a] = dm;
      dir_d[a]  = dm || dp;
      hnb_d[a]  = dm ? hm : hp;
      hh_d[a]   = (pp > lo - dd) && (pp < hi + dd);
    end
  end

  // Stage three: one mask bit per neighbor combination, in emission order.
  logic                        c3_valid_q;
  ogb_pkg::hit_t               c3_q, c3_d;

  always_comb begin
    logic ok;
    logic [2:0] sel;
    c3_d.id = c2_id_q;
    c3_d.home = c2_cell_q;
    for (int a = 0; a < 3; a++) begin
      c3_d.nb[a] = c2_dirm_q[a] ? c2_cell_q[a] - 1'b1 : c2_cell_q[a] + 1'b1;
    end
    c3_d.mask[0] = 1'b1;
    for (int m = 1; m < ogb_pkg::NCOMB; m++) begin
      sel = 3'(m);
      ok  = !(&c2_in_q);
      for (int a = 0; a < 3; a++) begin
        // Bit two of the combination selects x, bit zero selects z.
        if (sel[2-a]) begin
          ok = ok && c2_dir_q[a] && c2_hnb_q[a];
        end else begin
          ok = ok && c2_hh_q[a];
        end
      end
      c3_d.mask[m] = ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_valid_q <= 1'b0;
      c2_valid_q <= 1'b0;
      c3_valid_q <= 1'b0;
    end else if (en_i) begin
      c1_valid_q <= valid_i;
      c2_valid_q <= c1_valid_q;
      c3_valid_q <= c2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_id_q   <= div_i.id;
      c1_cell_q <= c1_cell_d;
      c1_lo_q   <= c1_lo_d;
      c1_p_q    <= div_i.p;
      c2_id_q   <= c1_id_q;
      c2_cell_q <= c1_cell_q;
      c2_in_q   <= in_d;
      c2_dirm_q <= dirm_d;
      c2_dir_q  <= dir_d;
      c2_hnb_q  <= hnb_d;
      c2_hh_q   <= hh_d;
      c3_q      <= c3_d;
    end
  end

  assign valid_o = c3_valid_q;
  assign hit_o   = c3_q;

endmodule

### rtl/ogb_emit.sv
// Output register that walks the hit mask and sends one cell per transaction.
`timescale 1ns / 1ps
module ogb_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  ogb_pkg::hit_t                 hit_i,
  output logic                          load_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ogb_pkg::EDGE_W-1:0]    out_edge_id_o,
  output logic [ogb_pkg::CELL_W-1:0]    cell_x_o,
  output logic [ogb_pkg::CELL_W-1:0]    cell_y_o,
  output logic [ogb_pkg::CELL_W-1:0]    cell_z_o,
  output logic                          is_extended_o,
  output logic                          last_o
);

  logic                          busy_q, busy_d;
  ogb_pkg::hit_t                 cur_q, cur_d;
  logic [ogb_pkg::NCOMB-1:0]     low, rest;
  logic                          take;

  assign low  = cur_q.mask & (~cur_q.mask + 1'b1);
  assign rest = cur_q.mask & ~low;
  assign take = busy_q && !out_stall_i;
  assign load_o = !busy_q || (take && rest == '0);

  always_comb begin
    busy_d = busy_q;
    cur_d  = cur_q;
    if (load_o) begin
      busy_d = valid_i;
      cur_d  = hit_i;
    end else if (take) begin
      cur_d.mask = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assign out_valid_o   = busy_q;
  assign out_edge_id_o = cur_q.id;
  assign cell_x_o      = |(low & 8'hF0) ? cur_q.nb[0] : cur_q.home[0];
  assign cell_y_o      = |(low & 8'hCC) ? cur_q.nb[1] : cur_q.home[1];
  assign cell_z_o      = |(low & 8'hAA) ? cur_q.nb[2] : cur_q.home[2];
  assign is_extended_o = !low[0];
  assign last_o        = (rest == '0);

endmodule

### rtl/overlapping_grid_binning.sv
// Top level of the overlapping grid binning block: configuration registers and pipeline.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                payload
//  --------  ---------  -----------------------  ------------------------------------------
//  input     in         in_valid_i / in_stall_o  edge_id_i, first_{x,y,z}_i, second_{x,y,z}_i
//  output    out        out_valid_o / out_stall_i out_edge_id_o, cell_{x,y,z}_o,
//                                                is_extended_o, last_o
//  config    in         cfg_we_i                 cfg_index_i, cfg_wdata_i
//
// An edge transaction can be taken in every cycle in which in_stall_o is low. Its first result
// passes through one midpoint stage, nine divider stages (one quotient bit each), three
// classify stages and the output register. An edge near cell faces gives up to eight results,
// one per cycle while out_stall_i is low, and the input stalls until the last result is taken.
// Reset clears all valid bits and loads the register reset values. A stall on a full output
// register freezes the whole pipeline in place.
module overlapping_grid_binning (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ogb_pkg::IDX_W-1:0]       cfg_index_i,
  input  logic [ogb_pkg::COORD_W-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ogb_pkg::EDGE_W-1:0]      edge_id_i,
  input  logic [ogb_pkg::COORD_W-1:0]     first_x_i,
  input  logic [ogb_pkg::COORD_W-1:0]     first_y_i,
  input  logic [ogb_pkg::COORD_W-1:0]     first_z_i,
  input  logic [ogb_pkg::COORD_W-1:0]     second_x_i,
  input  logic [ogb_pkg::COORD_W-1:0]     second_y_i,
  input  logic [ogb_pkg::COORD_W-1:0]     second_z_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ogb_pkg::EDGE_W-1:0]      out_edge_id_o,
  output logic [ogb_pkg::CELL_W-1:0]      cell_x_o,
  output logic [ogb_pkg::CELL_W-1:0]      cell_y_o,
  output logic [ogb_pkg::CELL_W-1:0]      cell_z_o,
  output logic                            is_extended_o,
  output logic                            last_o
);

  // Configuration registers, kept raw as written.
  logic [2:0][ogb_pkg::COORD_W-1:0] org_q;
  logic [ogb_pkg::SIZE_W-1:0]       cube_q, margin_q;
  logic [2:0][ogb_pkg::CNT_W-1:0]   cells_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q    <= '0;
      cube_q   <= ogb_pkg::SIZE_W'(4096);
      margin_q <= '0;
      cells_q  <= {3{ogb_pkg::CNT_W'(1)}};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ogb_pkg::REG_ORIGIN_X:  org_q[0]   <= cfg_wdata_i;
        ogb_pkg::REG_ORIGIN_Y:  org_q[1]   <= cfg_wdata_i;
        ogb_pkg::REG_ORIGIN_Z:  org_q[2]   <= cfg_wdata_i;
        ogb_pkg::REG_CUBE_SIZE: cube_q     <= cfg_wdata_i[ogb_pkg::SIZE_W-1:0];
        ogb_pkg::REG_MARGIN:    margin_q   <= cfg_wdata_i[ogb_pkg::SIZE_W-1:0];
        ogb_pkg::REG_CELLS_X:   cells_q[0] <= cfg_wdata_i[ogb_pkg::CNT_W-1:0];
        ogb_pkg::REG_CELLS_Y:   cells_q[1] <= cfg_wdata_i[ogb_pkg::CNT_W-1:0];
        ogb_pkg::REG_CELLS_Z:   cells_q[2] <= cfg_wdata_i[ogb_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived values: a zero cube size acts as one, cell counts clamp to the grid limits.
  // Sizes are kept doubled so the doubled midpoint needs no rounding.
  ogb_pkg::cfg_t cfg;
  always_comb begin
    cfg.org = org_q;
    cfg.c2  = {((cube_q == '0) ? ogb_pkg::SIZE_W'(1) : cube_q), 1'b0};
    cfg.d2  = {margin_q, 1'b0};
    for (int a = 0; a < 3; a++) begin
      if (cells_q[a] == '0) begin
        cfg.last_cell[a] = '0;
      end else if (cells_q[a] > ogb_pkg::CNT_W'(256)) begin
        cfg.last_cell[a] = '1;
      end else begin
        cfg.last_cell[a] = ogb_pkg::CELL_W'(cells_q[a] - 1'b1);
      end
    end
  end

  // The whole pipeline advances whenever the output register can take a new edge.
  logic          en;
  logic          dv_valid, hit_valid;
  ogb_pkg::div_t dv;
  ogb_pkg::hit_t hit;

  assign in_stall_o = !en;

  ogb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .edge_id_i (edge_id_i),
    .first_i   ({first_z_i, first_y_i, first_x_i}),
    .second_i  ({second_z_i, second_y_i, second_x_i}),
    .cfg_i     (cfg),
    .valid_o   (dv_valid),
    .div_o     (dv)
  );

  ogb_class u_class (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_valid),
    .div_i   (dv),
    .cfg_i   (cfg),
    .valid_o (hit_valid),
    .hit_o   (hit)
  );

  ogb_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (hit_valid),
    .hit_i         (hit),
    .load_o        (en),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_edge_id_o (out_edge_id_o),
    .cell_x_o      (cell_x_o),
    .cell_y_o      (cell_y_o),
    .cell_z_o      (cell_z_o),
    .is_extended_o (is_extended_o),
    .last_o        (last_o)
  );

endmodule

### rtl/ogb_checker.sv
// Port-level checks for the grid binning block and the bind that attaches them.
`timescale 1ns / 1ps
module ogb_checker (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_stall_o,
  input  logic out_valid_o,
  input  logic out_stall_i,
  input  logic is_extended_o,
  input  logic last_o
);

  a_valid_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output register");

  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && is_extended_o)
    else $error("run ended without last flag");

  a_hold_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output is stalled");

endmodule

bind overlapping_grid_binning ogb_checker u_ogb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .is_extended_o (is_extended_o),
  .last_o        (last_o)
);

### tb/sv/tb.sv
// Self-checking testbench for the overlapping grid binning block.
`timescale 1ns / 1ps
module tb;

  // One expected output transaction.
  typedef struct {
    logic [ogb_pkg::EDGE_W-1:0] id;
    logic [ogb_pkg::CELL_W-1:0] cx, cy, cz;
    logic                       ext;
    logic                       last;
  } bin_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ogb_pkg::IDX_W-1:0] cfg_index_i = '0;
  logic [ogb_pkg::COORD_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ogb_pkg::EDGE_W-1:0] edge_id_i = '0;
  logic [ogb_pkg::COORD_W-1:0] first_x_i = '0, first_y_i = '0, first_z_i = '0;
  logic [ogb_pkg::COORD_W-1:0] second_x_i = '0, second_y_i = '0, second_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ogb_pkg::EDGE_W-1:0] out_edge_id_o;
  logic [ogb_pkg::CELL_W-1:0] cell_x_o, cell_y_o, cell_z_o;
  logic is_extended_o, last_o;

  overlapping_grid_binning DUT (.*);

  // Local copy of the grid registers.
  logic signed [ogb_pkg::COORD_W-1:0] grid_org [3];
  logic [ogb_pkg::SIZE_W-1:0] grid_cube;
  logic [ogb_pkg::SIZE_W-1:0] grid_margin;
  logic [ogb_pkg::CNT_W-1:0] grid_cells [3];

  bin_t pending_bins [$];
  int errors = 0;
  int long_hold = 0;   // cycles of forced output stall still to run
  int stall_pct = 30;  // output stall probability in percent

  initial forever #5 clk_i = ~clk_i;

  // Prints one line per mismatch and counts it.
  task automatic report(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Works out every bin the edge falls into, in the block's emission order.
  task automatic predict_bins(input logic [ogb_pkg::EDGE_W-1:0] id,
                              input logic signed [ogb_pkg::COORD_W-1:0] a [3],
                              input logic signed [ogb_pkg::COORD_W-1:0] b [3]);
    longint p [3], home [3], dir [3], cnt [3], c [3];
    longint c2, d2, lo, hi, q;
    bit in_box, hit;
    bin_t r;
    in_box = 1;
    c2 = 2 * ((grid_cube == 0) ? 1 : longint'(grid_cube));
    d2 = 2 * longint'(grid_margin);
    for (int ax = 0; ax < 3; ax++) begin
      cnt[ax] = (grid_cells[ax] == 0) ? 1 : longint'(grid_cells[ax]);
      if (cnt[ax] > 256) cnt[ax] = 256;
      p[ax] = longint'(a[ax]) + longint'(b[ax]) - 2 * longint'(grid_org[ax]);
      q = (p[ax] < 0) ? 0 : p[ax] / c2;
      if (q >= cnt[ax]) q = cnt[ax] - 1;
      home[ax] = q;
      lo = q * c2;
      hi = lo + c2;
      if (p[ax] < lo + d2 || p[ax] > hi - d2) in_box = 0;
      if (p[ax] - d2 < lo) dir[ax] = -1;
      else if (p[ax] + d2 > hi) dir[ax] = 1;
      else dir[ax] = 0;
      if (q == 0 && dir[ax] == -1) dir[ax] = 0;
      if (q == cnt[ax] - 1 && dir[ax] == 1) dir[ax] = 0;
    end
    r.id = id;
    r.cx = ogb_pkg::CELL_W'(home[0]);
    r.cy = ogb_pkg::CELL_W'(home[1]);
    r.cz = ogb_pkg::CELL_W'(home[2]);
    r.ext = 0; r.last = 0;
    pending_bins = {pending_bins, r};
    if (!in_box) begin
      for (int i = 0; i < (dir[0] != 0 ? 2 : 1); i++)
        for (int j = 0; j < (dir[1] != 0 ? 2 : 1); j++)
          for (int k = 0; k < (dir[2] != 0 ? 2 : 1); k++) begin
            if (i == 0 && j == 0 && k == 0) continue;
            c[0] = home[0] + (i ? dir[0] : 0);
            c[1] = home[1] + (j ? dir[1] : 0);
            c[2] = home[2] + (k ? dir[2] : 0);
            hit = 1;
            for (int ax = 0; ax < 3; ax++)
              if (p[ax] <= c[ax] * c2 - d2 || p[ax] >= c[ax] * c2 + c2 + d2) hit = 0;
            if (hit) begin
              r.cx = ogb_pkg::CELL_W'(c[0]);
              r.cy = ogb_pkg::CELL_W'(c[1]);
              r.cz = ogb_pkg::CELL_W'(c[2]);
              r.ext = 1;
              pending_bins = {pending_bins, r};
            end
          end
    end
    pending_bins[pending_bins.size() - 1].last = 1;
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input ogb_pkg::reg_idx_e idx, input longint val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val[ogb_pkg::COORD_W-1:0];
    case (idx)
      ogb_pkg::REG_ORIGIN_X: grid_org[0] = val[ogb_pkg::COORD_W-1:0];
      ogb_pkg::REG_ORIGIN_Y: grid_org[1] = val[ogb_pkg::COORD_W-1:0];
      ogb_pkg::REG_ORIGIN_Z: grid_org[2] = val[ogb_pkg::COORD_W-1:0];
      ogb_pkg::REG_CUBE_SIZE: grid_cube = val[ogb_pkg::SIZE_W-1:0];
      ogb_pkg::REG_MARGIN: grid_margin = val[ogb_pkg::SIZE_W-1:0];
      ogb_pkg::REG_CELLS_X: grid_cells[0] = val[ogb_pkg::CNT_W-1:0];
      ogb_pkg::REG_CELLS_Y: grid_cells[1] = val[ogb_pkg::CNT_W-1:0];
      default: grid_cells[2] = val[ogb_pkg::CNT_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_grid(input longint ox, oy, oz, cube, marg, nx, ny, nz);
    write_reg(ogb_pkg::REG_ORIGIN_X, ox);
    write_reg(ogb_pkg::REG_ORIGIN_Y, oy);
    write_reg(ogb_pkg::REG_ORIGIN_Z, oz);
    write_reg(ogb_pkg::REG_CUBE_SIZE, cube);
    write_reg(ogb_pkg::REG_MARGIN, marg);
    write_reg(ogb_pkg::REG_CELLS_X, nx);
    write_reg(ogb_pkg::REG_CELLS_Y, ny);
    write_reg(ogb_pkg::REG_CELLS_Z, nz);
  endtask

  // Offers one edge at a falling edge and holds it until the block takes it.
  task automatic send_edge(input logic [ogb_pkg::EDGE_W-1:0] id,
                           input logic signed [ogb_pkg::COORD_W-1:0] a [3],
                           input logic signed [ogb_pkg::COORD_W-1:0] b [3]);
    edge_id_i <= id;
    first_x_i <= a[0]; first_y_i <= a[1]; first_z_i <= a[2];
    second_x_i <= b[0]; second_y_i <= b[1]; second_z_i <= b[2];
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_bins(id, a, b);
    @(negedge clk_i);
    if ($urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  // Waits until every expected result has come, plus the pipeline depth.
  // Called at the falling edge where the last send ended.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_bins.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // A random coordinate: mostly within the grid, sometimes anywhere.
  function automatic logic signed [ogb_pkg::COORD_W-1:0] rand_coord(input int axis);
    longint span, v;
    span = longint'(grid_cube) * ((grid_cells[axis] == 0) ? 1 : grid_cells[axis]);
    if ($urandom_range(0, 9) == 0) return ogb_pkg::COORD_W'($urandom);
    v = longint'(grid_org[axis]) + longint'($urandom_range(0, 1000)) * (span + 2) / 1000
        - 1;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[ogb_pkg::COORD_W-1:0];
  endfunction

  task automatic send_random(input int n);
    logic signed [ogb_pkg::COORD_W-1:0] a [3], b [3];
    for (int i = 0; i < n; i++) begin
      for (int ax = 0; ax < 3; ax++) begin
        a[ax] = rand_coord(ax);
        // Equal ends put the midpoint right on chosen spots, near faces too.
        b[ax] = ($urandom_range(0, 1) == 0) ? a[ax] : rand_coord(ax);
      end
      send_edge(ogb_pkg::EDGE_W'($urandom), a, b);
    end
  endtask

  task automatic test_directed;
    logic signed [ogb_pkg::COORD_W-1:0] a [3], b [3];
    set_grid(0, 0, 0, 4096, 1024, 4, 4, 4);
    // Edge id and coordinate extremes.
    a = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF}; b = a;
    send_edge('1, a, b);
    a = '{24'h800000, 24'h800000, 24'h800000}; b = a;
    send_edge('0, a, b);
    a = '{24'h7FFFFF, 24'h800000, 24'h000000}; b = '{24'h800000, 24'h7FFFFF, 24'h0};
    send_edge(20'h55555, a, b);
    // Point at an inner corner gets all seven neighbours.
    a = '{4096, 4096, 4096}; b = '{4097, 4095, 4096};
    send_edge(20'hAAAAA, a, b);
    a = '{4096 + 100, 8192 - 100, 6000}; b = a;
    send_edge(7, a, b);
    // Grid border faces.
    a = '{100, 100, 100}; b = a;
    send_edge(8, a, b);
    a = '{16383, 16383, 16383}; b = a;
    send_edge(9, a, b);
    // Exactly on the widened face: strict test keeps it out.
    a = '{4096 + 1024, 2048, 2048}; b = a;
    send_edge(10, a, b);
    a = '{4096 - 1024, 2048, 2048}; b = a;
    send_edge(11, a, b);
    drain();
    // Zero cube size and out-of-range cell counts.
    set_grid(-5, 3, 0, 0, 0, 0, 511, 257);
    a = '{-20, 300, 7}; b = '{4, 301, 9};
    send_edge(12, a, b);
    a = '{1000, -1000, 200}; b = a;
    send_edge(13, a, b);
    drain();
    // Biggest cube and margin.
    set_grid(24'h800000, 24'h7FFFFF, 12345, 24'h7FFFFF, 24'h7FFFFF, 256, 1, 2);
    a = '{0, 0, 0}; b = '{24'h7FFFFF, 24'h800000, 24'h7FFFFF};
    send_edge(14, a, b);
    a = '{24'h7FFFFF, 24'h7FFFFF, 24'h800000}; b = a;
    send_edge(15, a, b);
    drain();
    // Unknown register indexes are ignored by the block.
    for (int i = 8; i < 16; i++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1; cfg_index_i <= ogb_pkg::IDX_W'(i); cfg_wdata_i <= '1;
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    a = '{10, 10, 10}; b = a;
    send_edge(16, a, b);
    drain();
  endtask

  task automatic test_random_small_grid;
    set_grid($urandom_range(0, 200) - 100, -4000, 777, 400, 90, 8, 6, 5);
    send_random(45);
    drain();
    set_grid(-300000, 250000, -1, 40, 19, 256, 256, 256);
    send_random(45);
    drain();
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall input.
  task automatic test_backpressure;
    set_grid(0, 0, 0, 1000, 300, 16, 16, 16);
    long_hold = 60;
    send_random(50);
    drain();
    // Sender pauses until every result has come, then resumes.
    send_random(10);
    drain();
    send_random(10);
    drain();
  endtask

  task automatic test_no_stall;
    stall_pct = 0;
    set_grid(1, 2, 3, 3000, 0, 3, 3, 3);
    send_random(30);
    drain();
    stall_pct = 60;
    set_grid(-8000, 8000, 0, 2000, 999, 200, 9, 1);
    send_random(20);
    drain();
  endtask

  // Output stall pattern, changed at falling edges.
  always @(negedge clk_i) begin
    if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Checks each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bins.size() == 0) begin
        report($sformatf("unexpected result for edge %0h", out_edge_id_o));
      end else begin
        bin_t e;
        e = pending_bins.pop_front();
        if (out_edge_id_o !== e.id)
          report($sformatf("edge id %0h, expected %0h", out_edge_id_o, e.id));
        if ({cell_x_o, cell_y_o, cell_z_o} !== {e.cx, e.cy, e.cz})
          report($sformatf("edge %0h cell %0d,%0d,%0d expected %0d,%0d,%0d", e.id,
                           cell_x_o, cell_y_o, cell_z_o, e.cx, e.cy, e.cz));
        if (is_extended_o !== e.ext)
          report($sformatf("edge %0h extended flag %b", e.id, is_extended_o));
        if (last_o !== e.last)
          report($sformatf("edge %0h last flag %b", e.id, last_o));
      end
    end
  end

  initial begin
    grid_org = '{0, 0, 0};
    grid_cube = 4096;
    grid_margin = 0;
    grid_cells = '{1, 1, 1};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Reset values first: everything bins to the single cube.
    send_random(5);
    drain();
    test_directed();
    test_random_small_grid();
    test_backpressure();
    test_no_stall();
    if (errors == 0 && pending_bins.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
rtl/ogb_pkg.sv
rtl/ogb_front.sv
rtl/ogb_class.sv
rtl/ogb_emit.sv
rtl/overlapping_grid_binning.sv
rtl/ogb_checker.sv
tb/sv/tb.sv
